@@ hw/rtl/rotation_period_column_scheduler_core_macros.svh @@
// assertion macros for the rotation period column scheduler
// no dependencies; included by the files that carry assertions
`ifndef ROTATION_PERIOD_COLUMN_SCHEDULER_CORE_MACROS_SVH
`define ROTATION_PERIOD_COLUMN_SCHEDULER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RPCS_ASSERT_IMPLIES(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define RPCS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define RPCS_ASSERT_IMPLIES(lbl, ck, rs, ante, cons, msg)
`define RPCS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)
`endif
`endif

@@ hw/rtl/rpcs_pkg.sv @@
// shared types and constants for the rotation period column scheduler
// no dependencies
`timescale 1ns / 1ps

package rpcs_pkg;

  // parameter defaults
  localparam int COLUMN_BITS_DEF = 7;
  localparam int TIMER_BITS_DEF  = 16;

  // fixed field widths
  localparam int PERIOD_CFG_BITS = 16;
  localparam int ACQ_BITS        = 8;
  localparam int OFFSET_BITS     = 7;
  localparam int COUNT_BITS      = 8;
  localparam int CFG_INDEX_BITS  = 3;

  // register reset values
  localparam logic [PERIOD_CFG_BITS-1:0] MIN_PERIOD_RST     = 16'd3250;
  localparam logic [PERIOD_CFG_BITS-1:0] MAX_PERIOD_RST     = 16'd25000;
  localparam logic [PERIOD_CFG_BITS-1:0] LOCK_THRESHOLD_RST = 16'd3250;
  localparam logic [PERIOD_CFG_BITS-1:0] COARSE_STEP_RST    = 16'd100;
  localparam logic [PERIOD_CFG_BITS-1:0] FINE_STEP_RST      = 16'd10;
  localparam logic [ACQ_BITS-1:0]        ACQUIRE_COUNT_RST  = 8'd10;
  localparam logic [OFFSET_BITS-1:0]     COLUMN_OFFSET_RST  = 7'd48;

  // register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MIN_PERIOD     = 3'd0,
    REG_MAX_PERIOD     = 3'd1,
    REG_LOCK_THRESHOLD = 3'd2,
    REG_COARSE_STEP    = 3'd3,
    REG_FINE_STEP      = 3'd4,
    REG_ACQUIRE_COUNT  = 3'd5,
    REG_COLUMN_OFFSET  = 3'd6
  } cfg_reg_t;

  // event codes
  localparam logic FUNC_INDEX  = 1'b0;
  localparam logic FUNC_COLUMN = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_COLUMN  = 2'd0,
    STATUS_LOCKED  = 2'd1,
    STATUS_ACQUIRE = 2'd2,
    STATUS_RANGE   = 2'd3
  } status_t;

endpackage

@@ hw/rtl/rotation_period_column_scheduler_core.sv @@
// rotation period column scheduler, top level
// depends on rpcs_pkg and rotation_period_column_scheduler_core_macros.svh
`timescale 1ns / 1ps
`include "rotation_period_column_scheduler_core_macros.svh"

// Tracks the revolution period of a rotating LED display and schedules column
// compare times. Each input word is an event: an index pulse (func 0) or a
// column compare match (func 1), with the timer value at the event. Every
// event gives exactly one result word: status, the next compare time, a flag
// saying whether that time should be loaded, and the frame column to show.
// The block takes one event per clock cycle sustained while out_stall is low.
// Three registers sit on the path: an input register, a stage that applies the
// period tracking and column state update, and the output register, loaded
// through the single period-times-column multiplier and the add of the index time.
// Results wait in the output register, and bubbles in front of it are absorbed,
// so input is taken while a result is stalled as long as a stage is free. There
// is no clearing pass after reset. Configuration writes are always ready and
// should be issued only while no event is in flight.
module rotation_period_column_scheduler_core #(
  parameter int COLUMN_BITS = rpcs_pkg::COLUMN_BITS_DEF,
  parameter int TIMER_BITS  = rpcs_pkg::TIMER_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // event input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 func,
  input  logic [TIMER_BITS-1:0]                now,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output rpcs_pkg::status_t                    status,
  output logic [TIMER_BITS-1:0]                compare_time,
  output logic                                 compare_valid,
  output logic [COLUMN_BITS-1:0]               column,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rpcs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [rpcs_pkg::PERIOD_CFG_BITS-1:0] cfg_data
);

  import rpcs_pkg::*;

  // comparison width: holds a period or config value plus a step without wrap
  localparam int WW = ((TIMER_BITS > PERIOD_CFG_BITS) ? TIMER_BITS : PERIOD_CFG_BITS) + 2;
  // column sum width
  localparam int CW = ((COLUMN_BITS > COUNT_BITS) ? COLUMN_BITS : COUNT_BITS) + 1;
  localparam int PW = TIMER_BITS + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  // configuration registers
  logic [PERIOD_CFG_BITS-1:0] min_period;
  logic [PERIOD_CFG_BITS-1:0] max_period;
  logic [PERIOD_CFG_BITS-1:0] lock_threshold;
  logic [PERIOD_CFG_BITS-1:0] coarse_step;
  logic [PERIOD_CFG_BITS-1:0] fine_step;
  logic [ACQ_BITS-1:0]        acquire_count;
  logic [OFFSET_BITS-1:0]     column_offset;

  // tracking state
  logic [TIMER_BITS-1:0] period;
  logic [TIMER_BITS-1:0] last_index_time;
  logic [COUNT_BITS-1:0] column_count;
  logic [TIMER_BITS-1:0] period_next;
  logic [TIMER_BITS-1:0] last_index_time_next;
  logic [COUNT_BITS-1:0] column_count_next;

  // input register
  logic                  s0_v;
  logic                  s0_func;
  logic [TIMER_BITS-1:0] s0_now;

  // update stage register
  logic                   s1_v;
  status_t                s1_status;
  logic [TIMER_BITS-1:0]  s1_period;
  logic [COUNT_BITS-1:0]  s1_mult;
  logic [TIMER_BITS-1:0]  s1_base;
  logic [COLUMN_BITS-1:0] s1_col;
  status_t                s1_status_next;
  logic [TIMER_BITS-1:0]  s1_period_next;
  logic [COUNT_BITS-1:0]  s1_mult_next;
  logic [TIMER_BITS-1:0]  s1_base_next;
  logic [COLUMN_BITS-1:0] s1_col_next;

  // output register
  logic                   out_v;
  status_t                out_status;
  logic [TIMER_BITS-1:0]  out_time;
  logic                   out_cvalid;
  logic [COLUMN_BITS-1:0] out_col;

  // flow control
  logic out_free;
  logic s1_free;
  logic s1_adv;
  logic s0_free;
  logic s0_adv;
  logic in_take;

  assign out_free = !out_v || !out_stall;
  assign s1_adv   = s1_v && out_free;
  assign s1_free  = !s1_v || out_free;
  assign s0_adv   = s0_v && s1_free;
  assign s0_free  = !s0_v || s1_free;
  assign in_stall = !s0_free;
  assign in_take  = in_valid && s0_free;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_period     <= MIN_PERIOD_RST;
      max_period     <= MAX_PERIOD_RST;
      lock_threshold <= LOCK_THRESHOLD_RST;
      coarse_step    <= COARSE_STEP_RST;
      fine_step      <= FINE_STEP_RST;
      acquire_count  <= ACQUIRE_COUNT_RST;
      column_offset  <= COLUMN_OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_PERIOD:     min_period     <= cfg_data;
        REG_MAX_PERIOD:     max_period     <= cfg_data;
        REG_LOCK_THRESHOLD: lock_threshold <= cfg_data;
        REG_COARSE_STEP:    coarse_step    <= cfg_data;
        REG_FINE_STEP:      fine_step      <= cfg_data;
        REG_ACQUIRE_COUNT:  acquire_count  <= cfg_data[ACQ_BITS-1:0];
        REG_COLUMN_OFFSET:  column_offset  <= cfg_data[OFFSET_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (s0_free) begin
      s0_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_func <= func;
      s0_now  <= now;
    end
  end

  // period measurement and smoothing
  logic [TIMER_BITS-1:0] meas;
  logic [WW-1:0]         meas_x;
  logic [WW-1:0]         coarse_x;
  logic [WW-1:0]         fine_x;
  logic                  in_window;
  logic                  locked;
  // coarse then fine nudges; each check sees the period left by the one before
  logic [WW-1:0]         p0_x;
  logic [WW-1:0]         p0_up;
  logic [TIMER_BITS-1:0] p1;
  logic [WW-1:0]         p1_x;
  logic [WW-1:0]         p1_dn;
  logic [TIMER_BITS-1:0] p2;
  logic [WW-1:0]         p2_x;
  logic [WW-1:0]         p2_up;
  logic [TIMER_BITS-1:0] p3;
  logic [WW-1:0]         p3_x;
  logic [WW-1:0]         p3_dn;
  logic [TIMER_BITS-1:0] p4;
  logic [TIMER_BITS-1:0] p_inc;
  logic [COUNT_BITS-1:0] cc_inc;
  logic [CW-1:0]         col_sum;

  assign meas      = s0_now - last_index_time;
  assign meas_x    = WW'(meas);
  assign coarse_x  = WW'(coarse_step);
  assign fine_x    = WW'(fine_step);
  assign in_window = (meas_x > WW'(min_period)) && (meas_x < WW'(max_period));
  assign locked    = WW'(period) > WW'(lock_threshold);

  assign p0_x  = WW'(period);
  assign p0_up = p0_x + coarse_x;
  assign p1    = (p0_up < meas_x) ? p0_up[TIMER_BITS-1:0] : period;
  assign p1_x  = WW'(p1);
  assign p1_dn = p1_x - coarse_x;
  assign p2    = (p1_x > meas_x + coarse_x) ? p1_dn[TIMER_BITS-1:0] : p1;
  assign p2_x  = WW'(p2);
  assign p2_up = p2_x + fine_x;
  assign p3    = (p2_up < meas_x) ? p2_up[TIMER_BITS-1:0] : p2;
  assign p3_x  = WW'(p3);
  assign p3_dn = p3_x - fine_x;
  assign p4    = (p3_x > meas_x + fine_x) ? p3_dn[TIMER_BITS-1:0] : p3;

  assign p_inc   = period + TIMER_BITS'(1);
  assign cc_inc  = column_count + COUNT_ONE;
  assign col_sum = CW'(column_offset) + CW'(cc_inc);

  // next state and the operands handed to the schedule stage
  always_comb begin
    period_next          = period;
    last_index_time_next = last_index_time;
    column_count_next    = column_count;
    s1_status_next       = STATUS_COLUMN;
    s1_period_next       = period;
    s1_mult_next         = cc_inc;
    s1_base_next         = last_index_time;
    s1_col_next          = col_sum[COLUMN_BITS-1:0];
    if (s0_func == FUNC_INDEX) begin
      last_index_time_next = s0_now;
      column_count_next    = COUNT_ONE;
      s1_mult_next         = COUNT_ONE;
      s1_base_next         = s0_now;
      s1_col_next          = '0;
      if (!in_window) begin
        s1_status_next = STATUS_RANGE;
      end else if (locked) begin
        period_next    = p4;
        s1_status_next = STATUS_LOCKED;
        s1_period_next = p4;
        s1_col_next    = COLUMN_BITS'(column_offset);
      end else begin
        // acquisition: count valid measurements, then take the measurement
        period_next    = (WW'(p_inc) > WW'(acquire_count)) ? meas : p_inc;
        s1_status_next = STATUS_ACQUIRE;
      end
    end else begin
      column_count_next = cc_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period          <= '0;
      last_index_time <= '0;
      column_count    <= '0;
    end else if (s0_adv) begin
      period          <= period_next;
      last_index_time <= last_index_time_next;
      column_count    <= column_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s1_free) begin
      s1_v <= s0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv) begin
      s1_status <= s1_status_next;
      s1_period <= s1_period_next;
      s1_mult   <= s1_mult_next;
      s1_base   <= s1_base_next;
      s1_col    <= s1_col_next;
    end
  end

  // schedule: period * column / 2^COLUMN_BITS + index time
  logic [PW-1:0]         prod;
  logic [PW-1:0]         prod_sh;
  logic [TIMER_BITS-1:0] sched;
  logic                  has_time;

  assign prod     = PW'(s1_period) * PW'(s1_mult);
  assign prod_sh  = prod >> COLUMN_BITS;
  assign sched    = prod_sh[TIMER_BITS-1:0] + s1_base;
  assign has_time = (s1_status == STATUS_COLUMN) || (s1_status == STATUS_LOCKED);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (out_free) begin
      out_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status <= s1_status;
      out_time   <= has_time ? sched : '0;
      out_cvalid <= has_time;
      out_col    <= s1_col;
    end
  end

  assign out_valid     = out_v;
  assign status        = out_status;
  assign compare_time  = out_time;
  assign compare_valid = out_cvalid;
  assign column        = out_col;

  `RPCS_ASSERT_IMPLIES(a_cvalid_status, clk, rst, out_valid, compare_valid == ((status == STATUS_COLUMN) || (status == STATUS_LOCKED)), "compare_valid disagrees with status")
  `RPCS_ASSERT_IMPLIES(a_idle_fields, clk, rst, out_valid && !compare_valid, (compare_time == '0) && (column == '0), "fields not cleared on an index without schedule")
  `RPCS_ASSERT_NEXT(a_index_restart, clk, rst, s0_adv && (s0_func == FUNC_INDEX), column_count == COUNT_ONE, "column count not restarted by index")
  `RPCS_ASSERT_NEXT(a_index_time, clk, rst, s0_adv && (s0_func == FUNC_INDEX), last_index_time == $past(s0_now), "index time not captured")

endmodule

@@ verif/rotation_period_column_scheduler_checker.sv @@
// result checker for the rotation period column scheduler
// watches event, result and register channels; depends on rpcs_pkg
`timescale 1ns / 1ps

module rotation_period_column_scheduler_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic                                 func,
  input  logic [rpcs_pkg::TIMER_BITS_DEF-1:0]  now,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  rpcs_pkg::status_t                    status,
  input  logic [rpcs_pkg::TIMER_BITS_DEF-1:0]  compare_time,
  input  logic                                 compare_valid,
  input  logic [rpcs_pkg::COLUMN_BITS_DEF-1:0] column,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [rpcs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [rpcs_pkg::PERIOD_CFG_BITS-1:0] cfg_data,
  output int                                   fail_count,
  output int                                   outstanding,
  output int                                   checked
);

  import rpcs_pkg::*;

  localparam int TW = TIMER_BITS_DEF;
  localparam int CW = COLUMN_BITS_DEF;

  typedef struct packed {
    status_t         st;
    logic [TW-1:0]   ctime;
    logic            cvalid;
    logic [CW-1:0]   col;
  } sched_word_t;

  // register copies
  logic [PERIOD_CFG_BITS-1:0] min_p, max_p, lock_th, coarse, fine;
  logic [ACQ_BITS-1:0]        acq_lim;
  logic [OFFSET_BITS-1:0]     col_off;

  // tracker state
  logic [TW-1:0]         period;
  logic [TW-1:0]         last_idx;
  logic [COUNT_BITS-1:0] col_count;

  sched_word_t sched_q[$];
  sched_word_t want;

  // move p toward meas by one step, with a dead band of the same size
  function automatic logic [TW-1:0] pull_toward(logic [TW-1:0] p, logic [TW-1:0] meas,
                                                logic [PERIOD_CFG_BITS-1:0] step);
    int sp, sm, ss;
    sp = p;
    sm = meas;
    ss = step;
    if (sp < sm - ss) begin
      p = p + step;
      sp = p;
    end
    if (sp > sm + ss) p = p - step;
    return p;
  endfunction

  function automatic logic [TW-1:0] column_time(logic [COUNT_BITS-1:0] n);
    logic [TW+COUNT_BITS-1:0] prod;
    prod = period * n;
    return TW'((prod >> CW) + last_idx);
  endfunction

  // advance the tracker by one event and give the word it should produce
  function automatic sched_word_t track_event(logic f, logic [TW-1:0] t);
    sched_word_t r;
    logic [TW-1:0] meas;
    r = '{st: STATUS_COLUMN, ctime: '0, cvalid: 1'b0, col: '0};
    if (f == FUNC_INDEX) begin
      meas = t - last_idx;
      last_idx = t;
      col_count = COUNT_BITS'(1);
      if (meas > min_p && meas < max_p) begin
        if (period > lock_th) begin
          period = pull_toward(period, meas, coarse);
          period = pull_toward(period, meas, fine);
          r.st = STATUS_LOCKED;
          r.ctime = column_time(COUNT_BITS'(1));
          r.cvalid = 1'b1;
          r.col = col_off;
        end else begin
          period = period + 1'b1;
          if (period > acq_lim) period = meas;
          r.st = STATUS_ACQUIRE;
        end
      end else begin
        r.st = STATUS_RANGE;
      end
    end else begin
      col_count = col_count + 1'b1;
      r.ctime = column_time(col_count);
      r.cvalid = 1'b1;
      r.col = col_off + col_count[CW-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      min_p = MIN_PERIOD_RST;
      max_p = MAX_PERIOD_RST;
      lock_th = LOCK_THRESHOLD_RST;
      coarse = COARSE_STEP_RST;
      fine = FINE_STEP_RST;
      acq_lim = ACQUIRE_COUNT_RST;
      col_off = COLUMN_OFFSET_RST;
      period = '0;
      last_idx = '0;
      col_count = '0;
      sched_q.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_MIN_PERIOD:     min_p = cfg_data;
          REG_MAX_PERIOD:     max_p = cfg_data;
          REG_LOCK_THRESHOLD: lock_th = cfg_data;
          REG_COARSE_STEP:    coarse = cfg_data;
          REG_FINE_STEP:      fine = cfg_data;
          REG_ACQUIRE_COUNT:  acq_lim = cfg_data[ACQ_BITS-1:0];
          REG_COLUMN_OFFSET:  col_off = cfg_data[OFFSET_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        checked++;
        if (sched_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] unexpected result word: status %s time %h valid %b column %0d",
                     $realtime, status.name(), compare_time, compare_valid, column);
        end else begin
          want = sched_q.pop_front();
          if (want.st != status || want.ctime != compare_time ||
              want.cvalid != compare_valid || want.col != column) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"[%0t] result mismatch: expected status %s time %h valid %b ",
                        "column %0d, got status %s time %h valid %b column %0d"},
                       $realtime, want.st.name(), want.ctime, want.cvalid, want.col,
                       status.name(), compare_time, compare_valid, column);
          end
        end
      end
      if (in_valid && !in_stall) sched_q.push_back(track_event(func, now));
    end
    outstanding <= sched_q.size();
  end

endmodule

@@ verif/rotation_period_column_scheduler_core_tb.sv @@
// testbench top for the rotation period column scheduler
// drives events, register writes and back-pressure; depends on rpcs_pkg,
// the block itself and rotation_period_column_scheduler_checker
`timescale 1ns / 1ps

module rotation_period_column_scheduler_core_tb;

  import rpcs_pkg::*;

  // run ends here whatever happens; far above the slowest legal run
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst = 1'b1;

  // event channel
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       func = FUNC_INDEX;
  logic [TIMER_BITS_DEF-1:0]  now = '0;

  // result channel
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  status_t                    status;
  logic [TIMER_BITS_DEF-1:0]  compare_time;
  logic                       compare_valid;
  logic [COLUMN_BITS_DEF-1:0] column;

  // register write channel
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_BITS-1:0]  cfg_index = '0;
  logic [PERIOD_CFG_BITS-1:0] cfg_data = '0;

  int fail_count, outstanding, checked;

  // stimulus bookkeeping
  logic [TIMER_BITS_DEF-1:0]  stamp = '0;   // timer value of the last index word
  logic [PERIOD_CFG_BITS-1:0] cfg_set [0:6];
  bit                         quiet = 1'b0; // no gaps and no stalls when set
  int                         words_sent = 0;
  int                         settings_used = 1;
  int                         cycle_count = 0;

  rotation_period_column_scheduler_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .now(now),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .compare_time(compare_time), .compare_valid(compare_valid), .column(column),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  rotation_period_column_scheduler_checker sched_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .now(now),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .compare_time(compare_time), .compare_valid(compare_valid), .column(column),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count), .outstanding(outstanding), .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles with %0d words still awaited",
                 cycle_count, outstanding);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // result back-pressure: random stall bursts, none once quiet
  initial begin : result_backpressure
    int hold;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 14);
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // offer one event word, with an occasional gap in front of it;
  // valid stays up between back-to-back words
  task automatic send_word(input logic f, input logic [TIMER_BITS_DEF-1:0] t);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    now <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // index pulse a given number of timer ticks after the previous one
  task automatic send_index(input int delta);
    stamp = stamp + delta[TIMER_BITS_DEF-1:0];
    send_word(FUNC_INDEX, stamp);
  endtask

  // column match; its timer value is ignored by the block, so randomise it
  task automatic send_column();
    send_word(FUNC_COLUMN, TIMER_BITS_DEF'($urandom));
  endtask

  // drop valid and wait until every predicted word has come back,
  // then let the pipeline drain before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // write the whole register set, one word per accepted beat
  task automatic set_regs(input int mn, input int mx, input int lk, input int cs,
                          input int fs, input int ac, input int off);
    cfg_reg_t r;
    cfg_set[REG_MIN_PERIOD]     = mn[15:0];
    cfg_set[REG_MAX_PERIOD]     = mx[15:0];
    cfg_set[REG_LOCK_THRESHOLD] = lk[15:0];
    cfg_set[REG_COARSE_STEP]    = cs[15:0];
    cfg_set[REG_FINE_STEP]      = fs[15:0];
    cfg_set[REG_ACQUIRE_COUNT]  = ac[15:0];
    cfg_set[REG_COLUMN_OFFSET]  = off[15:0];
    settle();
    r = r.first();
    do begin
      cfg_valid <= 1'b1;
      cfg_index <= r;
      cfg_data <= cfg_set[r];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      r = r.next();
    end while (r != r.first());
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // revolutions: an index near a drifting nominal period followed by a run of
  // columns; some indexes are plain noise so the window edges get hit too
  task automatic run_traffic(input int budget, input bit with_long_run);
    int lo, hi, nominal, delta, cols, sent, k;
    lo = cfg_set[REG_MIN_PERIOD];
    hi = cfg_set[REG_MAX_PERIOD];
    nominal = (hi > lo + 1) ? $urandom_range(lo + 1, hi - 1) : 0;
    sent = 0;
    while (sent < budget) begin
      if (hi > lo + 1 && $urandom_range(0, 7) == 0) nominal = $urandom_range(lo + 1, hi - 1);
      if (hi <= lo + 1 || $urandom_range(0, 6) == 0) begin
        delta = $urandom_range(0, 65535);
      end else begin
        delta = nominal + int'($urandom_range(0, 800)) - 400;
        if (delta <= lo) delta = lo + 1;
        if (delta >= hi) delta = hi - 1;
      end
      send_index(delta);
      sent++;
      // one very long revolution wraps the 8-bit column count
      if (with_long_run) begin
        cols = 260;
        with_long_run = 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        cols = $urandom_range(9, 140);
      end else begin
        cols = $urandom_range(0, 8);
      end
      for (k = 0; k < cols && sent < budget; k++) begin
        send_column();
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    int lo;
    cfg_set[REG_MIN_PERIOD]     = MIN_PERIOD_RST;
    cfg_set[REG_MAX_PERIOD]     = MAX_PERIOD_RST;
    cfg_set[REG_LOCK_THRESHOLD] = LOCK_THRESHOLD_RST;
    cfg_set[REG_COARSE_STEP]    = COARSE_STEP_RST;
    cfg_set[REG_FINE_STEP]      = FINE_STEP_RST;
    cfg_set[REG_ACQUIRE_COUNT]  = 16'(ACQUIRE_COUNT_RST);
    cfg_set[REG_COLUMN_OFFSET]  = 16'(COLUMN_OFFSET_RST);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset register values
    send_word(FUNC_COLUMN, 16'hFFFF); // column before any index, period still zero
    send_index(0);                    // zero measurement, out of range, timer at zero
    send_index(3250);                 // exactly min_period: rejected
    send_index(3251);                 // just above min: first acquisition
    send_index(24999);                // just below max: acquisition
    send_index(25000);                // exactly max_period: rejected
    send_index(65535);                // largest measurement, timer wraps
    repeat (9) send_index(8000);      // acquisition count runs out, period loaded
    send_index(8500);                 // locked: coarse then fine step up
    send_index(7000);                 // coarse then fine step down
    send_index(8005);                 // inside both dead bands: no change
    send_index(8050);                 // inside coarse band, fine step only
    send_word(FUNC_COLUMN, 16'h0000);
    send_word(FUNC_COLUMN, 16'hAAAA);
    send_word(FUNC_COLUMN, 16'h5555);
    send_word(FUNC_COLUMN, 16'hFFFF);
    send_index(30000);                // out of range while locked

    // random traffic under reset values
    run_traffic(100, 1'b0);

    // widest window, immediate load, steps that can never act, top offset
    set_regs(0, 65535, 0, 65535, 0, 0, 127);
    run_traffic(80, 1'b0);

    // never locked: acquisition counter keeps running, zero offset
    set_regs(1000, 2000, 65535, 0, 65535, 255, 0);
    run_traffic(80, 1'b0);

    // random register set, with the long column run
    lo = $urandom_range(500, 6000);
    set_regs(lo, lo + $urandom_range(2, 20000), $urandom_range(0, 8000),
             $urandom_range(0, 600), $urandom_range(0, 60), $urandom_range(0, 20),
             $urandom_range(0, 127));
    run_traffic(300, 1'b1);

    // empty window: every index is out of range
    set_regs(65535, 0, 32768, 1, 1, 1, 64);
    run_traffic(30, 1'b0);

    // last stretch at full rate on both sides
    lo = $urandom_range(500, 6000);
    set_regs(lo, lo + $urandom_range(2, 20000), $urandom_range(0, 8000),
             $urandom_range(0, 600), $urandom_range(0, 60), $urandom_range(0, 20),
             $urandom_range(0, 127));
    quiet = 1'b1;
    run_traffic(80, 1'b0);

    // drain, then a few extra cycles for anything stray
    settle();
    repeat (10) @(posedge clk);

    $display("sent %0d event words across %0d register settings", words_sent, settings_used);
    $display("checked %0d result words, %0d failures", checked, fail_count + outstanding);
    if (fail_count == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/rpcs_pkg.sv
hw/rtl/rotation_period_column_scheduler_core.sv
verif/rotation_period_column_scheduler_checker.sv
verif/rotation_period_column_scheduler_core_tb.sv
